FILE: rtl/core/bdbp_pkg.sv
package bdbp_pkg;

  // Default sizes
  localparam int ALPHABET_DEF    = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  // Weight every entry holds after reset
  localparam int INIT_WEIGHT = 256;

  // Port widths fixed by the item fields
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 8;
  localparam int ENTRY_W  = 16;
  localparam int PROB_W   = 16;
  localparam int CFG_W    = 64;
  localparam int NUM_REGS = 4;
  localparam int PADDR_W  = 5;

  // Divider: one quotient bit per step, quotient may reach 2^16
  localparam int QUOT_W   = PROB_W + 1;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

  localparam logic [PROB_W-1:0] HALF_Q16 = 16'h8000;
  localparam logic [PROB_W-1:0] MAX_Q16  = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BIT   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_MASK0 = 2'd0,
    REG_MASK1 = 2'd1,
    REG_MASK2 = 2'd2,
    REG_MASK3 = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DIV
  } state_e;

endpackage

FILE: rtl/core/bdbp_if.sv
interface bdbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdbp_pkg::OP_W-1:0]      op;
  logic [bdbp_pkg::INDEX_W-1:0]   entry_index;
  logic [bdbp_pkg::ENTRY_W-1:0]   entry_weight;
  logic                           coded_bit;

  modport source (output valid, op, entry_index, entry_weight, coded_bit, input ready);
  modport sink   (input valid, op, entry_index, entry_weight, coded_bit, output ready);
endinterface

interface bdbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [bdbp_pkg::PROB_W-1:0]    p_one;
  logic [bdbp_pkg::INDEX_W-1:0]   likely_byte;

  modport source (output valid, p_one, likely_byte, input ready);
  modport sink   (input valid, p_one, likely_byte, output ready);
endinterface

FILE: rtl/core/byte_distribution_bit_predictor.sv
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    op, entry_index, entry_weight, coded_bit
// out_if    out  valid/ready    p_one, likely_byte
// apb       in   psel/penable   vocab_mask_0..3 at byte address 8*i, 64-bit data
//
// A load item is written straight into the weight memory. A start or bit item reads
// the weight memory once per entry of its interval (all ALPHABET entries for a start),
// then the drain state and 17 divider steps; the single memory read port paces the scan.
// Reset restores bounds, sets masks to all ones and clears per-entry valid bits at once.
// A finished result waits in the output register while the next item is taken; the
// divider holds on its last step while that register is still full.
module byte_distribution_bit_predictor #(
  parameter int ALPHABET    = bdbp_pkg::ALPHABET_DEF,
  parameter int WEIGHT_BITS = bdbp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bdbp_in_if.sink                        in_if,
  bdbp_out_if.source                     out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdbp_pkg::PADDR_W-1:0]   paddr,
  input  logic [bdbp_pkg::CFG_W-1:0]     pwdata,
  output logic [bdbp_pkg::CFG_W-1:0]     prdata,
  output logic                           pready
);

  localparam int IW = $clog2(ALPHABET);
  localparam int SW = WEIGHT_BITS + IW;
  localparam int RW = SW + 1;
  localparam logic [IW-1:0]          TOP_IDX = IW'(ALPHABET - 1);
  localparam logic [WEIGHT_BITS-1:0] INIT_W  = WEIGHT_BITS'(bdbp_pkg::INIT_WEIGHT);

  bdbp_pkg::state_e state_q, state_d;

  logic [bdbp_pkg::NUM_REGS-1:0][bdbp_pkg::CFG_W-1:0] mask_q;

  logic [WEIGHT_BITS-1:0] mem [ALPHABET];
  logic [ALPHABET-1:0]    wvld_q;
  logic                   we;
  logic [IW-1:0]          waddr;
  logic [WEIGHT_BITS-1:0] wdata;

  logic [IW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IW-1:0]          addr_q, addr_d;
  logic                   start_q, start_d;

  logic                   rd_vld_q;
  logic [IW-1:0]          rd_idx_q;
  logic [WEIGHT_BITS-1:0] rd_data_q;
  logic                   rd_ent_vld_q;

  logic [SW-1:0]          den_q, den_d, num_q, num_d;
  logic [IW-1:0]          best_q, best_d;
  logic [WEIGHT_BITS-1:0] bestw_q, bestw_d;

  logic [RW-1:0]                    rem_q, rem_d, trial;
  logic [bdbp_pkg::PROB_W-1:0]      quot_q, quot_d;
  logic [bdbp_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                             qbit;

  logic                             ov_q, ov_d;
  logic [bdbp_pkg::PROB_W-1:0]      p_q, p_d;
  logic [bdbp_pkg::INDEX_W-1:0]     lb_q, lb_d;

  logic                   accept;
  logic                   allowed;
  logic [WEIGHT_BITS-1:0] w_eff;
  logic [bdbp_pkg::INDEX_W-1:0] rd_byte;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == bdbp_pkg::ST_IDLE);

  // Configuration port
  assign pready = 1'b1;
  assign prdata = mask_q[paddr[4:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (psel && penable && pwrite) begin
      case (bdbp_pkg::reg_e'(paddr[4:3]))
        bdbp_pkg::REG_MASK0: mask_q[0] <= pwdata;
        bdbp_pkg::REG_MASK1: mask_q[1] <= pwdata;
        bdbp_pkg::REG_MASK2: mask_q[2] <= pwdata;
        bdbp_pkg::REG_MASK3: mask_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Weight as seen at the read stage; a start drops disallowed bytes
  assign rd_byte = bdbp_pkg::INDEX_W'(rd_idx_q);
  assign allowed = mask_q[rd_byte[7:6]][rd_byte[5:0]];
  always_comb begin
    w_eff = rd_ent_vld_q ? rd_data_q : INIT_W;
    if (start_q && !allowed) begin
      w_eff = '0;
    end
  end

  // Memory write port: loads, and zeroing during a start scan
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_q;
    wdata = '0;
    if (accept && bdbp_pkg::op_e'(in_if.op) == bdbp_pkg::OP_LOAD &&
        {1'b0, in_if.entry_index} < 9'(ALPHABET)) begin
      we    = 1'b1;
      waddr = IW'(in_if.entry_index);
      wdata = WEIGHT_BITS'(in_if.entry_weight);
    end else if (rd_vld_q && start_q && !allowed) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q       <= '0;
      rd_ent_vld_q <= 1'b0;
    end else begin
      if (we) begin
        wvld_q[waddr] <= 1'b1;
      end
      rd_ent_vld_q <= wvld_q[addr_q];
    end
  end

  // Divider step
  always_comb begin
    trial = (cnt_q == '0) ? RW'(num_q) : {rem_q[RW-2:0], 1'b0};
    qbit  = (trial >= RW'(den_q));
  end

  // Next state, scan and divide
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    addr_d  = addr_q;
    start_d = start_q;
    den_d   = den_q;
    num_d   = num_q;
    best_d  = best_q;
    bestw_d = bestw_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_if.ready;
    p_d     = p_q;
    lb_d    = lb_q;

    // Accumulate the entry read last cycle
    if (rd_vld_q) begin
      den_d = den_q + SW'(w_eff);
      if (rd_idx_q > mid_q) begin
        num_d = num_q + SW'(w_eff);
      end
      if (rd_idx_q == lo_q || w_eff > bestw_q) begin
        best_d  = rd_idx_q;
        bestw_d = w_eff;
      end
    end

    case (state_q)
      bdbp_pkg::ST_IDLE: begin
        if (accept) begin
          case (bdbp_pkg::op_e'(in_if.op))
            bdbp_pkg::OP_START: begin
              lo_d    = '0;
              hi_d    = TOP_IDX;
              start_d = 1'b1;
              state_d = bdbp_pkg::ST_SCAN;
            end
            bdbp_pkg::OP_BIT: begin
              if (lo_q < hi_q) begin
                if (in_if.coded_bit) begin
                  lo_d = lo_q + ((hi_q - lo_q) >> 1) + IW'(1);
                end else begin
                  hi_d = lo_q + ((hi_q - lo_q) >> 1);
                end
              end
              start_d = 1'b0;
              state_d = bdbp_pkg::ST_SCAN;
            end
            default: ;
          endcase
          mid_d  = lo_d + ((hi_d - lo_d) >> 1);
          addr_d = lo_d;
          den_d  = '0;
          num_d  = '0;
        end
      end
      bdbp_pkg::ST_SCAN: begin
        if (addr_q == hi_q) begin
          state_d = bdbp_pkg::ST_LAST;
        end else begin
          addr_d = addr_q + IW'(1);
        end
      end
      bdbp_pkg::ST_LAST: begin
        cnt_d   = '0;
        state_d = bdbp_pkg::ST_DIV;
      end
      bdbp_pkg::ST_DIV: begin
        if (!(cnt_q == bdbp_pkg::DIV_LAST && ov_d)) begin
          rem_d  = qbit ? trial - RW'(den_q) : trial;
          quot_d = {quot_q[bdbp_pkg::PROB_W-2:0], qbit};
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == bdbp_pkg::DIV_LAST) begin
            ov_d = 1'b1;
            lb_d = bdbp_pkg::INDEX_W'(best_q);
            if (den_q == '0) begin
              p_d = bdbp_pkg::HALF_Q16;
            end else if (quot_q[bdbp_pkg::PROB_W-1]) begin
              p_d = bdbp_pkg::MAX_Q16;
            end else begin
              p_d = {quot_q[bdbp_pkg::PROB_W-2:0], qbit};
            end
            state_d = bdbp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bdbp_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bdbp_pkg::ST_IDLE;
      lo_q     <= '0;
      hi_q     <= TOP_IDX;
      rd_vld_q <= 1'b0;
      ov_q     <= 1'b0;
      start_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      rd_vld_q <= (state_q == bdbp_pkg::ST_SCAN);
      ov_q     <= ov_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mid_q    <= mid_d;
    addr_q   <= addr_d;
    rd_idx_q <= addr_q;
    den_q    <= den_d;
    num_q    <= num_d;
    best_q   <= best_d;
    bestw_q  <= bestw_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    p_q      <= p_d;
    lb_q     <= lb_d;
  end

  assign out_if.valid       = ov_q;
  assign out_if.p_one       = p_q;
  assign out_if.likely_byte = lb_q;

endmodule

FILE: rtl/core/bdbp_checker.sv
module bdbp_assert (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [bdbp_pkg::OP_W-1:0]     in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdbp_pkg::PROB_W-1:0]   out_p_one,
  input logic                          pready
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_p_one))
    else $error("result dropped or changed while stalled");

  // Drop ready after a prediction item enters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op == bdbp_pkg::OP_START || in_op == bdbp_pkg::OP_BIT)
    |=> !in_ready)
    else $error("input taken during a scan");

  // Stay ready after a load item enters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op == bdbp_pkg::OP_LOAD |=> in_ready)
    else $error("load did not complete in one cycle");

  // Keep the configuration port ready
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind byte_distribution_bit_predictor bdbp_assert u_bdbp_assert (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_p_one (out_if.p_one),
  .pready    (pready)
);
